// File: rtl/iheap_pkg.sv
package iheap_pkg;

    // heap geometry
    localparam int MAX_VERTICES = 256;
    localparam int SLOT_BITS    = $clog2(MAX_VERTICES);
    localparam int CNT_BITS     = $clog2(MAX_VERTICES + 1);
    localparam int VTX_BITS     = 8;
    localparam int KEY_BITS     = 32;

    typedef logic [1:0]                 t_cmd;
    typedef logic [1:0]                 t_status;
    typedef logic [VTX_BITS-1:0]        t_vtx;
    typedef logic signed [KEY_BITS-1:0] t_key;
    typedef logic [CNT_BITS-1:0]        t_cnt;
    typedef logic [SLOT_BITS-1:0]       t_slot;

    // one heap slot: vertex and its key
    typedef struct packed {
        t_vtx vtx;
        t_key key;
    } t_entry;

    localparam t_cmd CMD_INIT     = 2'd0;
    localparam t_cmd CMD_EXTRACT  = 2'd1;
    localparam t_cmd CMD_DECREASE = 2'd2;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_NOT_IN = 2'd2;

    localparam t_key KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

endpackage

// File: rtl/iheap_ram.sv
module iheap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/indexed_min_heap.sv
// channel   direction  handshake                   word
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_data (vertex count)
// in        in         i_in_valid / o_in_ready     i_command, i_vertex, i_new_key
// out       out        o_out_valid / i_out_ready   o_min_vertex, o_min_key, o_status,
//                                                  o_heap_count
//
// one command at a time; a sequencer drives one slot ram read and one compare per cycle
// init does one slot and map write per vertex; extract sifts the moved entry down and
// decrease-key sifts the entry up, one level at a time through the slot ram read port
// synchronous active-low reset clears the count and sets the vertex count to 256;
// the rams are not cleared
// a new command is taken while the last result waits; the result register stalls the
// sequencer only at its very end
module indexed_min_heap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  iheap_pkg::t_cnt    i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  iheap_pkg::t_cmd    i_command,
    input  iheap_pkg::t_vtx    i_vertex,
    input  iheap_pkg::t_key    i_new_key,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output iheap_pkg::t_vtx    o_min_vertex,
    output iheap_pkg::t_key    o_min_key,
    output iheap_pkg::t_status o_status,
    output iheap_pkg::t_cnt    o_heap_count
);

    import iheap_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE    = 15'h0001,
        S_INIT    = 15'h0002,
        S_EX_ROOT = 15'h0004,
        S_EX_LAST = 15'h0008,
        S_EX_SET  = 15'h0010,
        S_SD_L    = 15'h0020,
        S_SD_R    = 15'h0040,
        S_SD_CMP  = 15'h0080,
        S_DK_POS  = 15'h0100,
        S_DK_SLOT = 15'h0200,
        S_DK_CHK  = 15'h0400,
        S_SU_RD   = 15'h0800,
        S_SU_CMP  = 15'h1000,
        S_FINISH  = 15'h2000,
        S_DONE    = 15'h4000
    } t_state;

    typedef logic [SLOT_BITS+1:0] t_child;

    t_state  r_state, n_state;
    t_cnt    r_vcount, n_vcount;
    t_cnt    r_count, n_count;
    t_cnt    r_idx, n_idx;
    t_slot   r_at, n_at;
    t_entry  r_cur, n_cur;
    t_entry  r_left, n_left;
    t_vtx    r_res_vtx, n_res_vtx;
    t_key    r_res_key, n_res_key;
    t_status r_res_status, n_res_status;
    logic    r_out_valid, n_out_valid;
    t_vtx    r_out_vtx, n_out_vtx;
    t_key    r_out_key, n_out_key;
    t_status r_out_status, n_out_status;
    t_cnt    r_out_count, n_out_count;

    // ram ports
    logic   slot_we;
    t_slot  slot_wa;
    t_entry slot_wd;
    t_slot  slot_ra;
    t_entry slot_rd;
    logic   pos_we;
    t_slot  pos_wa;
    t_slot  pos_wd;
    t_slot  pos_ra;
    t_slot  pos_rd;

    // index arithmetic
    t_child l_idx;
    t_child r_idx_c;
    logic   left_in;
    logic   right_in;
    t_slot  parent;
    t_cnt   count_m1;
    t_slot  last;
    t_cnt   init_n;
    t_cnt   init_m1;
    logic   take_left;
    logic   take_right;
    t_key   best_key;

    assign l_idx    = {1'b0, r_at, 1'b1};
    assign r_idx_c  = l_idx + t_child'(1);
    assign left_in  = l_idx < t_child'(r_count);
    assign right_in = r_idx_c < t_child'(r_count);
    assign parent   = t_slot'((r_at - t_slot'(1)) >> 1);
    assign count_m1 = r_count - t_cnt'(1);
    assign last     = count_m1[SLOT_BITS-1:0];
    assign init_n   = (r_vcount > t_cnt'(MAX_VERTICES)) ? t_cnt'(MAX_VERTICES) : r_vcount;
    assign init_m1  = init_n - t_cnt'(1);

    // shared compare for sift-down: left against current, right against the better one
    assign take_left  = $signed(r_left.key) < $signed(r_cur.key);
    assign best_key   = take_left ? r_left.key : r_cur.key;
    assign take_right = right_in && ($signed(slot_rd.key) < $signed(best_key));

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_vcount     = r_vcount;
        n_count      = r_count;
        n_idx        = r_idx;
        n_at         = r_at;
        n_cur        = r_cur;
        n_left       = r_left;
        n_res_vtx    = r_res_vtx;
        n_res_key    = r_res_key;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_vtx    = r_out_vtx;
        n_out_key    = r_out_key;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        slot_we      = 1'b0;
        slot_wa      = '0;
        slot_wd      = '0;
        slot_ra      = '0;
        pos_we       = 1'b0;
        pos_wa       = '0;
        pos_wd       = '0;
        pos_ra       = '0;

        if (i_cfg_valid) begin
            n_vcount = i_cfg_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cur        = '{vtx: i_vertex, key: i_new_key};
                    n_res_vtx    = '0;
                    n_res_key    = '0;
                    n_res_status = ST_OK;
                    n_idx        = '0;
                    case (i_command)
                        CMD_INIT: begin
                            if (init_n == '0) begin
                                n_count = '0;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_INIT;
                            end
                        end
                        CMD_EXTRACT: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_EX_ROOT;
                            end
                        end
                        CMD_DECREASE: n_state = S_DK_POS;
                        default:      n_state = S_DONE;
                    endcase
                end
            end
            // identity fill at the largest key
            S_INIT: begin
                slot_we = 1'b1;
                slot_wa = r_idx[SLOT_BITS-1:0];
                slot_wd = '{vtx: r_idx[VTX_BITS-1:0], key: KEY_MAX};
                pos_we  = 1'b1;
                pos_wa  = r_idx[SLOT_BITS-1:0];
                pos_wd  = r_idx[SLOT_BITS-1:0];
                n_idx   = r_idx + t_cnt'(1);
                if (r_idx == init_m1) begin
                    n_count = init_n;
                    n_state = S_DONE;
                end
            end
            S_EX_ROOT: begin
                slot_ra = '0;
                n_state = S_EX_LAST;
            end
            S_EX_LAST: begin
                slot_ra   = last;
                n_res_vtx = slot_rd.vtx;
                n_res_key = slot_rd.key;
                n_state   = S_EX_SET;
            end
            // last entry becomes the root, held in r_cur while it sinks
            S_EX_SET: begin
                n_cur   = slot_rd;
                pos_we  = 1'b1;
                pos_wa  = r_res_vtx[SLOT_BITS-1:0];
                pos_wd  = last;
                n_count = count_m1;
                n_at    = '0;
                n_state = S_SD_L;
            end
            S_SD_L: begin
                if (!left_in) begin
                    n_state = S_FINISH;
                end else begin
                    slot_ra = l_idx[SLOT_BITS-1:0];
                    n_state = S_SD_R;
                end
            end
            S_SD_R: begin
                slot_ra = r_idx_c[SLOT_BITS-1:0];
                n_left  = slot_rd;
                n_state = S_SD_CMP;
            end
            // move the smaller child up into the hole
            S_SD_CMP: begin
                if (take_right || take_left) begin
                    slot_we = 1'b1;
                    slot_wa = r_at;
                    slot_wd = take_right ? slot_rd : r_left;
                    pos_we  = 1'b1;
                    pos_wa  = take_right ? slot_rd.vtx[SLOT_BITS-1:0]
                                         : r_left.vtx[SLOT_BITS-1:0];
                    pos_wd  = r_at;
                    n_at    = take_right ? r_idx_c[SLOT_BITS-1:0] : l_idx[SLOT_BITS-1:0];
                    n_state = S_SD_L;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DK_POS: begin
                pos_ra  = r_cur.vtx[SLOT_BITS-1:0];
                n_state = S_DK_SLOT;
            end
            // membership: mapped slot below count and holding this vertex
            S_DK_SLOT: begin
                n_at = pos_rd;
                if (t_cnt'(pos_rd) < r_count) begin
                    slot_ra = pos_rd;
                    n_state = S_DK_CHK;
                end else begin
                    n_res_status = ST_NOT_IN;
                    n_state      = S_DONE;
                end
            end
            S_DK_CHK: begin
                if (slot_rd.vtx == r_cur.vtx) begin
                    n_state = S_SU_RD;
                end else begin
                    n_res_status = ST_NOT_IN;
                    n_state      = S_DONE;
                end
            end
            S_SU_RD: begin
                if (r_at == '0) begin
                    n_state = S_FINISH;
                end else begin
                    slot_ra = parent;
                    n_state = S_SU_CMP;
                end
            end
            // pull the parent down while the new key is smaller
            S_SU_CMP: begin
                if ($signed(r_cur.key) < $signed(slot_rd.key)) begin
                    slot_we = 1'b1;
                    slot_wa = r_at;
                    slot_wd = slot_rd;
                    pos_we  = 1'b1;
                    pos_wa  = slot_rd.vtx[SLOT_BITS-1:0];
                    pos_wd  = r_at;
                    n_at    = parent;
                    n_state = S_SU_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            // drop the moving entry into its final slot
            S_FINISH: begin
                slot_we = 1'b1;
                slot_wa = r_at;
                slot_wd = r_cur;
                pos_we  = 1'b1;
                pos_wa  = r_cur.vtx[SLOT_BITS-1:0];
                pos_wd  = r_at;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_vtx    = r_res_vtx;
                    n_out_key    = r_res_key;
                    n_out_status = r_res_status;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= t_cnt'(256);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_vcount    <= n_vcount;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_at         <= n_at;
        r_cur        <= n_cur;
        r_left       <= n_left;
        r_res_vtx    <= n_res_vtx;
        r_res_key    <= n_res_key;
        r_res_status <= n_res_status;
        r_out_vtx    <= n_out_vtx;
        r_out_key    <= n_out_key;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    // slot store: vertex and key per heap slot
    iheap_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_VERTICES)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_we),
        .i_wr_addr (slot_wa),
        .i_wr_data (slot_wd),
        .i_rd_addr (slot_ra),
        .o_rd_data (slot_rd)
    );

    // position map: heap slot per vertex
    iheap_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (MAX_VERTICES)
    ) u_pos_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pos_we),
        .i_wr_addr (pos_wa),
        .i_wr_data (pos_wd),
        .i_rd_addr (pos_ra),
        .o_rd_data (pos_rd)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_min_vertex = r_out_vtx;
    assign o_min_key    = r_out_key;
    assign o_status     = r_out_status;
    assign o_heap_count = r_out_count;

    // an accepted command always leaves idle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready held after command accepted");

    // sift-down only visits slots inside the heap
    a_sift_down_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SD_R || r_state == S_SD_CMP) |-> (t_cnt'(r_at) < r_count))
        else $error("sift-down slot outside heap");

    // sift-up never compares the root against a parent
    a_sift_up_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SU_CMP) |-> (r_at != '0))
        else $error("sift-up compare at root");

    // heap never grows past its storage
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(MAX_VERTICES))
        else $error("heap count above capacity");

    // a result word appears only at the end of a command
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result word raised outside done");

endmodule
